@@ hdl/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1_pkg: shared types and constants of the SHA-1 hash engine
// Request and result structs, round constants, initial chaining values.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

	// One input request: a message byte and/or the end-of-message mark
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_item_t;

	// One result: a digest word with its position
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// Round variables a..e
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

	// Control of the message schedule window
	typedef struct packed {
		logic       byte_en;
		logic [7:0] byte_val;
		logic       word_en;
		logic       expand;
	} sched_ctrl_t;

	localparam int unsigned ROUND_W    = 7;

	localparam logic [ROUND_W-1:0] ROUND_EXPAND = 7'd16;
	localparam logic [ROUND_W-1:0] ROUND_K1     = 7'd20;
	localparam logic [ROUND_W-1:0] ROUND_K2     = 7'd40;
	localparam logic [ROUND_W-1:0] ROUND_K3     = 7'd60;
	localparam logic [ROUND_W-1:0] ROUND_LAST   = 7'd79;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [0:4][31:0] INIT_CHAIN = {
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
	localparam logic [7:0] PAD_ZERO_BYTE = 8'h00;
	localparam logic [5:0] LEN_POS       = 6'd56;
	localparam logic [5:0] LAST_POS      = 6'd63;
	localparam logic [2:0] LAST_INDEX    = 3'd4;
	localparam logic [2:0] DONE_INDEX    = 3'd5;

endpackage

`default_nettype wire

@@ hdl/sha1_sched.sv @@
// ----------------------------------------------------------------------------
// sha1_sched: message block buffer and schedule window
// A 512-bit shift line: bytes shift in while a block fills; in the rounds it
// shifts one word per round, appending w_word (expanded from round 16 on).
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_sched
	import sha1_pkg::*;
(
	input  wire logic        clk,
	input  wire sched_ctrl_t ctrl,
	output logic [31:0]      w_word
);

	logic [511:0] win_q;
	logic [31:0]  x_word;

	// oldest word sits at the top; word k holds W[t-1-k]
	assign x_word = win_q[32*2 +: 32] ^ win_q[32*7 +: 32]
		^ win_q[32*13 +: 32] ^ win_q[32*15 +: 32];
	assign w_word = ctrl.expand ? {x_word[30:0], x_word[31]} : win_q[32*15 +: 32];

	always_ff @(posedge clk) begin
		if (ctrl.byte_en) begin
			win_q <= {win_q[503:0], ctrl.byte_val};
		end else if (ctrl.word_en) begin
			win_q <= {win_q[479:0], w_word};
		end
	end

endmodule

`default_nettype wire

@@ hdl/sha1_round.sv @@
// ----------------------------------------------------------------------------
// sha1_round: one SHA-1 compression round
// Selects f and K by round number and forms the next a..e.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_round
	import sha1_pkg::*;
(
	input  wire work_t              cur,
	input  wire logic [ROUND_W-1:0] rnd,
	input  wire logic [31:0]        w_word,
	output work_t                   nxt
);

	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] t_val;

	always_comb begin
		if (rnd < ROUND_K1) begin
			f_val = (cur.b & cur.c) | (~cur.b & cur.d);
			k_val = K0;
		end else if (rnd < ROUND_K2) begin
			f_val = cur.b ^ cur.c ^ cur.d;
			k_val = K1;
		end else if (rnd < ROUND_K3) begin
			f_val = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k_val = K2;
		end else begin
			f_val = cur.b ^ cur.c ^ cur.d;
			k_val = K3;
		end
	end

	assign t_val = {cur.a[26:0], cur.a[31:27]} + f_val + cur.e + k_val + w_word;

	assign nxt.a = t_val;
	assign nxt.b = cur.a;
	assign nxt.c = {cur.b[1:0], cur.b[31:2]};
	assign nxt.d = cur.c;
	assign nxt.e = cur.d;

endmodule

`default_nettype wire

@@ hdl/sha1_hash_engine.sv @@
// ----------------------------------------------------------------------------
// sha1_hash_engine: streaming SHA-1 over a byte-wide message
// Byte requests fill a 64-byte block; each block is compressed by one shared
// round unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   data channel: one request per byte (has_byte), end_of_message closes the
//   message; a request with neither is taken and ignored. data_stall is high
//   whenever the engine is busy, so requests are taken one at a time.
//   digest channel: after the end request, five words leave in order,
//   index 0 first, last_word set on index 4.
// Flow:
//   a byte that neither completes a block nor ends the message leaves the
//   engine idle for the next request; the 64th byte of a block holds the
//   input through the 80 rounds (one per cycle in the round unit) and the
//   chaining add. The end request pads one byte per cycle, pausing once in
//   ST_ZERO at the length position, compresses one or two blocks and then
//   presents the digest words, one per cycle while digest_stall is low.
//   No byte is taken while a block is compressed.
// Reset: chaining words return to the initial values and the byte count
//   to zero; the same happens after each digest is delivered.
// Stall: a stalled digest word holds; the engine waits until all five go.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_hash_engine
	import sha1_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      data_valid,
	output logic           data_stall,
	input  wire in_item_t  data,
	output logic           digest_valid,
	input  wire logic      digest_stall,
	output out_item_t      digest
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_MARK,
		ST_ZERO,
		ST_LEN,
		ST_OUT
	} state_t;

	state_t               state_q;
	logic [ROUND_W-1:0]   rnd_q;
	logic [5:0]           pos_q;
	logic [60:0]          count_q;
	logic [63:0]          len_q;
	logic                 eom_q;
	logic                 pad_q;
	logic                 final_q;
	logic [0:4][31:0]     chain_q;
	work_t                work_q;
	out_item_t            out_q;
	logic                 out_valid_q;
	logic [2:0]           idx_q;

	logic                 accept;
	sched_ctrl_t          sched_ctrl;
	logic [31:0]          w_word;
	work_t                round_nxt;
	logic [0:4][31:0]     sum;

	assign data_stall   = (state_q != ST_IDLE);
	assign accept       = data_valid & ~data_stall;
	assign digest_valid = out_valid_q;
	assign digest       = out_q;

	always_comb begin
		sched_ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				sched_ctrl.byte_en  = accept & data.has_byte;
				sched_ctrl.byte_val = data.data_byte;
			end
			ST_ROUND: begin
				sched_ctrl.word_en = 1'b1;
				sched_ctrl.expand  = (rnd_q >= ROUND_EXPAND);
			end
			ST_MARK: begin
				sched_ctrl.byte_en  = 1'b1;
				sched_ctrl.byte_val = PAD_MARK_BYTE;
			end
			ST_ZERO: begin
				sched_ctrl.byte_en  = (pos_q != LEN_POS);
				sched_ctrl.byte_val = PAD_ZERO_BYTE;
			end
			ST_LEN: begin
				sched_ctrl.byte_en  = 1'b1;
				sched_ctrl.byte_val = len_q[63:56];
			end
			default: begin
				sched_ctrl = '0;
			end
		endcase
	end

	sha1_sched u_sched (
		.clk    (clk),
		.ctrl   (sched_ctrl),
		.w_word (w_word)
	);

	sha1_round u_round (
		.cur    (work_q),
		.rnd    (rnd_q),
		.w_word (w_word),
		.nxt    (round_nxt)
	);

	assign sum[0] = chain_q[0] + work_q.a;
	assign sum[1] = chain_q[1] + work_q.b;
	assign sum[2] = chain_q[2] + work_q.c;
	assign sum[3] = chain_q[3] + work_q.d;
	assign sum[4] = chain_q[4] + work_q.e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			pos_q       <= '0;
			count_q     <= '0;
			len_q       <= '0;
			eom_q       <= 1'b0;
			pad_q       <= 1'b0;
			final_q     <= 1'b0;
			chain_q     <= INIT_CHAIN;
			work_q      <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (data.has_byte) begin
							count_q <= count_q + 61'd1;
							pos_q   <= pos_q + 6'd1;
							if (pos_q == LAST_POS) begin
								state_q <= ST_ROUND;
								work_q  <= chain_q;
								eom_q   <= data.end_of_message;
							end else if (data.end_of_message) begin
								state_q <= ST_MARK;
							end
						end else if (data.end_of_message) begin
							state_q <= ST_MARK;
						end
					end
				end
				ST_ROUND: begin
					work_q <= round_nxt;
					if (rnd_q == ROUND_LAST) begin
						rnd_q   <= '0;
						state_q <= ST_ADD;
					end else begin
						rnd_q <= rnd_q + 7'd1;
					end
				end
				ST_ADD: begin
					chain_q <= sum;
					if (final_q) begin
						out_q       <= '{digest_word: sum[0], word_index: 3'd0, last_word: 1'b0};
						out_valid_q <= 1'b1;
						idx_q       <= 3'd1;
						final_q     <= 1'b0;
						pad_q       <= 1'b0;
						state_q     <= ST_OUT;
					end else if (eom_q) begin
						eom_q   <= 1'b0;
						state_q <= ST_MARK;
					end else if (pad_q) begin
						state_q <= ST_ZERO;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MARK: begin
					// message length in bits, wraps mod 2^64
					len_q <= {count_q, 3'b000};
					pad_q <= 1'b1;
					pos_q <= pos_q + 6'd1;
					if (pos_q == LAST_POS) begin
						state_q <= ST_ROUND;
						work_q  <= chain_q;
					end else begin
						state_q <= ST_ZERO;
					end
				end
				ST_ZERO: begin
					if (pos_q == LEN_POS) begin
						state_q <= ST_LEN;
					end else begin
						pos_q <= pos_q + 6'd1;
						if (pos_q == LAST_POS) begin
							state_q <= ST_ROUND;
							work_q  <= chain_q;
						end
					end
				end
				ST_LEN: begin
					len_q <= {len_q[55:0], 8'h00};
					pos_q <= pos_q + 6'd1;
					if (pos_q == LAST_POS) begin
						final_q <= 1'b1;
						state_q <= ST_ROUND;
						work_q  <= chain_q;
					end
				end
				ST_OUT: begin
					if (!digest_stall) begin
						if (idx_q == DONE_INDEX) begin
							out_valid_q <= 1'b0;
							chain_q     <= INIT_CHAIN;
							count_q     <= '0;
							state_q     <= ST_IDLE;
						end else begin
							out_q <= '{digest_word: chain_q[idx_q],
								word_index: idx_q,
								last_word: (idx_q == LAST_INDEX)};
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/sha1_hash_engine_test.sv @@
// ----------------------------------------------------------------------------
// sha1_hash_engine_test: self-checking regression of the SHA-1 hash engine
// Byte requests are streamed in from a queue while random idle bursts hit
// both channels. Every accepted request updates a local SHA-1 model, and each
// digest word that leaves the engine is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module sha1_hash_engine_test;
	import sha1_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT = 250000;
	localparam int DRAIN_CYCLES = 300;
	localparam int QUIET_TAIL = 40;   // last requests go without idling
	localparam int REPORT_MAX = 10;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      data_valid = 1'b0;
	logic      data_stall;
	in_item_t  data = '0;
	logic      digest_valid;
	logic      digest_stall = 1'b0;
	out_item_t digest;

	// stimulus side
	in_item_t  pending_reqs [$];
	int        total_reqs = 0;
	int        send_gap = 0;
	int        stall_left = 0;
	logic      req_taken = 1'b0;

	// SHA-1 model state
	logic [31:0] chain_h [5];
	logic [7:0]  blk [64];
	logic [60:0] msg_bytes = '0;
	out_item_t   digest_due [$];

	// bookkeeping
	int accepted_cnt = 0;
	int checked_words = 0;
	int mismatch_cnt = 0;
	int cycle_cnt = 0;

	sha1_hash_engine u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data         (data),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

	always #(HALF_PERIOD) clk = ~clk;

	initial begin
		for (int i = 0; i < 5; i++) chain_h[i] = INIT_CHAIN[i];
	end

	// One 80-round compression of blk into chain_h
	task automatic sha1_compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t, x;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 80; i++) begin
			x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
			w[i] = {x[30:0], x[31]};
		end
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int r = 0; r < 80; r++) begin
			if (r < int'(ROUND_K1)) begin
				f = (b & c) | (~b & d);
				k = K0;
			end else if (r < int'(ROUND_K2)) begin
				f = b ^ c ^ d;
				k = K1;
			end else if (r < int'(ROUND_K3)) begin
				f = (b & c) | (b & d) | (c & d);
				k = K2;
			end else begin
				f = b ^ c ^ d;
				k = K3;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[r];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		chain_h[0] = chain_h[0] + a;
		chain_h[1] = chain_h[1] + b;
		chain_h[2] = chain_h[2] + c;
		chain_h[3] = chain_h[3] + d;
		chain_h[4] = chain_h[4] + e;
	endtask

	// Fold one accepted request into the model; an end request queues the digest
	task automatic sha1_absorb(input in_item_t req);
		logic [5:0]  fill;
		logic [63:0] bit_len;
		out_item_t   word;
		if (req.has_byte) begin
			fill = msg_bytes[5:0];
			blk[fill] = req.data_byte;
			msg_bytes = msg_bytes + 61'd1;
			if (fill == LAST_POS) sha1_compress();
		end
		if (req.end_of_message) begin
			fill = msg_bytes[5:0];
			bit_len = {msg_bytes, 3'b000};
			blk[fill] = PAD_MARK_BYTE;
			for (int i = int'(fill) + 1; i < 64; i++) blk[i] = PAD_ZERO_BYTE;
			// no room for the length: spill into a second block
			if (fill >= LEN_POS) begin
				sha1_compress();
				for (int i = 0; i < 64; i++) blk[i] = PAD_ZERO_BYTE;
			end
			for (int i = 0; i < 8; i++) blk[int'(LEN_POS) + i] = bit_len[63 - 8*i -: 8];
			sha1_compress();
			for (int i = 0; i < 5; i++) begin
				word.digest_word = chain_h[i];
				word.word_index = 3'(i);
				word.last_word = (3'(i) == LAST_INDEX);
				digest_due.push_back(word);
			end
			for (int i = 0; i < 5; i++) chain_h[i] = INIT_CHAIN[i];
			msg_bytes = '0;
		end
	endtask

	task automatic push_req(input logic [7:0] b, input logic has, input logic eom);
		in_item_t req;
		req.data_byte = b;
		req.has_byte = has;
		req.end_of_message = eom;
		pending_reqs.push_back(req);
	endtask

	// Random message of len bytes; the end mark rides on the last byte or stands alone
	task automatic queue_message(input int len, input bit fused_end);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) push_req(8'($urandom), 1'b0, 1'b0);
			push_req(8'($urandom), 1'b1, fused_end && (i == len - 1));
		end
		if (!fused_end || len == 0) push_req(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic note_mismatch(input string what, input out_item_t want,
			input out_item_t got);
		mismatch_cnt++;
		if (mismatch_cnt <= REPORT_MAX)
			$display("%0t: %s: expected word %08h idx %0d last %0b, got %08h idx %0d last %0b",
				$realtime, what, want.digest_word, want.word_index, want.last_word,
				got.digest_word, got.word_index, got.last_word);
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!data_valid || req_taken)) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				data_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				data <= pending_reqs.pop_front();
				data_valid <= 1'b1;
				if (pending_reqs.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0)
					send_gap <= $urandom_range(1, 19);
			end else begin
				data_valid <= 1'b0;
			end
		end
	end

	// digest back-pressure
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			digest_stall <= 1'b1;
		end else if (pending_reqs.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 18);
			digest_stall <= 1'b1;
		end else begin
			digest_stall <= 1'b0;
		end
	end

	// monitor: predict on accepted requests, check accepted digest words
	always @(posedge clk) begin
		out_item_t want;
		req_taken <= arst_n && data_valid && !data_stall;
		if (arst_n) begin
			if (data_valid && !data_stall) begin
				sha1_absorb(data);
				accepted_cnt <= accepted_cnt + 1;
			end
			if (digest_valid && !digest_stall) begin
				checked_words <= checked_words + 1;
				if (digest_due.size() == 0) begin
					note_mismatch("unexpected digest word", '0, digest);
				end else begin
					want = digest_due.pop_front();
					if (digest.digest_word !== want.digest_word
							|| digest.word_index !== want.word_index
							|| digest.last_word !== want.last_word)
						note_mismatch("digest mismatch", want, digest);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding",
				cycle_cnt, digest_due.size());
			$display("sha1_hash_engine regression: fail");
			$finish;
		end
	end

	initial begin
		// directed: empty message, end with a byte, end alone, noise, extreme bytes
		push_req(8'hFF, 1'b0, 1'b1);
		push_req(8'h61, 1'b1, 1'b0);
		push_req(8'h62, 1'b1, 1'b0);
		push_req(8'h63, 1'b1, 1'b1);
		push_req(8'hFF, 1'b1, 1'b0);
		push_req(8'h00, 1'b0, 1'b0);
		push_req(8'h00, 1'b1, 1'b0);
		push_req(8'h55, 1'b0, 1'b1);
		push_req(8'h00, 1'b1, 1'b1);
		push_req(8'hAA, 1'b0, 1'b0);
		push_req(8'hFF, 1'b0, 1'b1);

		// random: a full block closed by the end mark on its last byte, then a
		// tail long enough that the length spills into a second block
		queue_message(64, 1'b1);
		queue_message(56, 1'($urandom_range(0, 1)));
		total_reqs = pending_reqs.size();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (accepted_cnt < total_reqs) @(posedge clk);
		while (digest_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests accepted, %0d digest words checked over %0d messages,",
			accepted_cnt, checked_words, checked_words / 5);
		$display("including empty messages and padding that spills into a second block");
		if (mismatch_cnt == 0)
			$display("sha1_hash_engine regression: pass");
		else
			$display("sha1_hash_engine regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/sha1_pkg.sv
hdl/sha1_sched.sv
hdl/sha1_round.sv
hdl/sha1_hash_engine.sv
tb/sv/sha1_hash_engine_test.sv
